// File: rtl/core/sqe_pkg.sv
// shared types, codes and defaults of the stack/queue engine
package sqe_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int WORD_BITS_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int OUT_W    = 32;
    localparam int IN_W     = 32;

    // apb register map: one 32-bit register per word address
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_PUSH_AT_TOP = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_DUMP = 3'd1,
        CMD_PEEK = 3'd2,
        CMD_POP  = 3'd3,
        CMD_SWAP = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_SHORT = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_PEEK,
        S_DUMP,
        S_SWAP_A,
        S_SWAP_B,
        S_SWAP_W
    } state_t;

endpackage

// File: rtl/core/sqe_ifs.sv
// command and result channel interfaces of the stack/queue engine
interface sqe_cmd_if;
    import sqe_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [IN_W-1:0]  push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface sqe_res_if;
    import sqe_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [OUT_W-1:0] word_out;
    logic                    word_valid;
    logic                    last_of_run;

    modport source (output valid, output status, output word_out, output word_valid,
                    output last_of_run, input ready);
    modport sink   (input valid, input status, input word_out, input word_valid,
                    input last_of_run, output ready);
endinterface

// File: rtl/core/sqe_ram.sv
// generic simple dual-port ram with registered read
module sqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/core/sqe_ctrl.sv
// command sequencer: ring pointers, memory access and result register
module sqe_ctrl #(
    parameter int DEPTH     = sqe_pkg::DEPTH_DEF,
    parameter int WORD_BITS = sqe_pkg::WORD_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_at_top,
    sqe_cmd_if.sink    cmd_ch,
    sqe_res_if.source  res_ch
);
    import sqe_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t               state_reg, state_next;
    logic [AW-1:0]        top_reg, top_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [WORD_BITS-1:0] tmp_reg, tmp_next;
    status_t              status_reg, status_next;

    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [OUT_W-1:0]     out_word_reg, out_word_next;
    logic                 out_wvalid_reg, out_wvalid_next;
    logic                 out_last_reg, out_last_next;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    logic                 accept, out_free, load;
    logic signed [63:0]   push_ext;
    logic signed [WORD_BITS-1:0] rd_word;
    logic signed [63:0]   rd_ext;
    logic [CW-1:0]        idx_inc;

    // base + off modulo DEPTH, both operands below DEPTH
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    sqe_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_ch.ready = (state_reg == S_IDLE);
    assign accept       = cmd_ch.valid && cmd_ch.ready;
    assign out_free     = !out_valid_reg || res_ch.ready;

    // truncate to the stored width, sign-extend back on the way out
    assign push_ext = 64'(cmd_ch.push_value);
    assign rd_word  = ram_rdata;
    assign rd_ext   = 64'(rd_word);
    assign idx_inc  = idx_reg + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            top_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        tmp_reg        <= tmp_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_word_reg   <= out_word_next;
        out_wvalid_reg <= out_wvalid_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        top_next        = top_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        tmp_next        = tmp_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        ram_waddr       = top_reg;
        ram_wdata       = push_ext[WORD_BITS-1:0];
        ram_re          = 1'b0;
        ram_raddr       = top_reg;
        load            = 1'b0;
        out_status_next = out_status_reg;
        out_word_next   = out_word_reg;
        out_wvalid_next = out_wvalid_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    state_next  = S_RESP;
                    case (cmd_ch.cmd)
                        CMD_PUSH:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (push_at_top)
                                begin
                                    top_next  = (top_reg == '0) ? AW'(DEPTH - 1)
                                                                : top_reg - AW'(1);
                                    ram_waddr = top_next;
                                end
                                else
                                begin
                                    ram_waddr = ring_add(top_reg, count_reg);
                                end
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (count_reg != '0)
                            begin
                                ram_re     = 1'b1;
                                idx_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        CMD_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                state_next = S_PEEK;
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                top_next   = ring_add(top_reg, CW'(1));
                                count_next = count_reg - CW'(1);
                            end
                        end
                        CMD_SWAP:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                status_next = ST_SHORT;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                state_next = S_SWAP_A;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SWAP_A:
            begin
                tmp_next   = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = ring_add(top_reg, CW'(1));
                state_next = S_SWAP_B;
            end
            S_SWAP_B:
            begin
                ram_we     = 1'b1;
                ram_waddr  = top_reg;
                ram_wdata  = ram_rdata;
                state_next = S_SWAP_W;
            end
            S_SWAP_W:
            begin
                ram_we      = 1'b1;
                ram_waddr   = ring_add(top_reg, CW'(1));
                ram_wdata   = tmp_reg;
                status_next = ST_OK;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    load            = 1'b1;
                    out_status_next = status_reg;
                    out_word_next   = '0;
                    out_wvalid_next = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_PEEK:
            begin
                if (out_free)
                begin
                    load            = 1'b1;
                    out_status_next = ST_OK;
                    out_word_next   = rd_ext[OUT_W-1:0];
                    out_wvalid_next = 1'b1;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DUMP:
            begin
                // read data holds while the result slot is busy
                if (out_free)
                begin
                    load            = 1'b1;
                    out_status_next = ST_OK;
                    out_word_next   = rd_ext[OUT_W-1:0];
                    out_wvalid_next = 1'b1;
                    out_last_next   = (idx_inc == count_reg);
                    if (idx_inc == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = ring_add(top_reg, idx_inc);
                        idx_next  = idx_inc;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = load ? 1'b1 : (res_ch.ready ? 1'b0 : out_valid_reg);
    end

    assign res_ch.valid       = out_valid_reg;
    assign res_ch.status      = out_status_reg;
    assign res_ch.word_out    = out_word_reg;
    assign res_ch.word_valid  = out_wvalid_reg;
    assign res_ch.last_of_run = out_last_reg;

`ifndef NO_ASSERTIONS
    // the word count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("word count above capacity");

    // the ring pointer stays inside the store
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg < AW'(DEPTH - 1) || top_reg == AW'(DEPTH - 1))
        else $error("top index outside the store");

    // the sequencer never reads and writes the memory in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("memory read and write overlap");

    // the word count moves only right after a command transaction
    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> $past(accept))
        else $error("word count changed without a command");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_ch.ready |=> $stable(out_word_reg) && $stable(out_last_reg))
        else $error("pending result overwritten");
`endif
endmodule

// File: rtl/core/stack_queue_engine_top.sv
// top level of the stack/queue engine: apb register and command sequencer
//
// Bounded store of signed words kept as a ring in one single-port-write,
// registered-read memory, with a top index and a word count. Each command
// transaction does one operation (push, dump, peek, pop, swap) and produces one
// result transaction, except dump of a non-empty store, which gives one per stored
// word from the top down, flagging the bottom word with last_of_run. Error cases
// (push when full, peek/pop when empty, swap with fewer than two words) report a
// status and leave the store as it was. Push, pop, error and unknown commands load
// their result after accept; peek reads on accept, then loads; swap reads both
// words and writes them back crossed, as both pass through the single read port
// and the single write port one at a time; dump reads on accept, then loads one
// result per word, one memory read per cycle while the consumer keeps up. Results
// land in an output register, so a finished result may wait there while the next
// command is accepted. The push_at_top register (offset 0x0, reset 1) selects
// stack mode (push at top) or queue mode (append at bottom); write it only while
// the block is idle. Entries of the store are undefined until written, and only
// written entries are ever read; no clearing pass is needed after reset.
module stack_queue_engine_top #(
    parameter int DEPTH     = sqe_pkg::DEPTH_DEF,
    parameter int WORD_BITS = sqe_pkg::WORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // apb configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sqe_pkg::PADDR_W-1:0]   paddr,
    input  logic [sqe_pkg::PDATA_W-1:0]   pwdata,
    output logic [sqe_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // command and result channels
    sqe_cmd_if.sink                       cmd_ch,
    sqe_res_if.source                     res_ch
);
    import sqe_pkg::*;

    logic push_at_top_reg, push_at_top_next;
    logic reg_hit;
    logic reg_write;

    // register index is the word address; low byte bits are ignored
    assign reg_hit   = (paddr[PADDR_W-1:2] == REG_PUSH_AT_TOP);
    assign reg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        push_at_top_next = push_at_top_reg;
        if (reg_write && reg_hit)
        begin
            push_at_top_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_at_top_reg <= 1'b1;
        end
        else
        begin
            push_at_top_reg <= push_at_top_next;
        end
    end

    // read back: only the mode bit is implemented
    assign prdata = reg_hit ? {{(PDATA_W-1){1'b0}}, push_at_top_reg} : '0;

    // sequencer with the ring memory and the result register
    sqe_ctrl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_at_top (push_at_top_reg),
        .cmd_ch      (cmd_ch),
        .res_ch      (res_ch)
    );
endmodule
